FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bpbs_pkg.sv
// ----------------------------------------------------------------------------
// Bounded pattern byte search package
// Register codes, field widths and the structs shared by the search modules.
// ----------------------------------------------------------------------------
package bpbs_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_0_7   = 3'd0,
		REG_PAT_8_15  = 3'd1,
		REG_PAT_16_23 = 3'd2,
		REG_PAT_24_31 = 3'd3,
		REG_PAT_LEN   = 3'd4
	} cfg_reg_t;

	// pattern storage is fixed by the register map
	localparam int PAT_WORDS = 4;
	localparam int PAT_BYTES = 32;
	localparam int PAT_IDX_W = 5;
	localparam int LEN_W     = 6;

	// payload widths
	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 32;

	// per-cell control for one cycle
	typedef struct packed {
		logic accept;   // a haystack byte is transferred
		logic shift;    // position not saturated: window moves
		logic clear;    // byte ends the haystack: window empties
		logic load;     // pipeline advances: compare bit is captured
	} cell_ctl_t;

	// stage-1 item as seen by the resolve stage
	typedef struct packed {
		logic                valid;
		logic                last;
		logic                zero_len;
		logic                cand;
		logic                wmatch;
		logic [OFFSET_W-1:0] offset;
	} s1_t;

endpackage

FILE: src/bpbs_if.sv
// ----------------------------------------------------------------------------
// Search channels
// Valid/ready channels for haystack bytes in and search results out.
// ----------------------------------------------------------------------------
interface bpbs_in_if;
	import bpbs_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] haystack_byte;
	logic              last_byte;

	modport source (output valid, output haystack_byte, output last_byte, input ready);
	modport sink   (input valid, input haystack_byte, input last_byte, output ready);
endinterface

interface bpbs_out_if;
	import bpbs_pkg::*;

	logic                valid;
	logic                ready;
	logic                match_found;
	logic [OFFSET_W-1:0] match_offset;

	modport source (output valid, output match_found, output match_offset, input ready);
	modport sink   (input valid, input match_found, input match_offset, output ready);
endinterface

FILE: src/bpbs_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one window byte, hands it to the next cell on a shift and registers
// the compare of its new byte against the pattern byte lined up with it.
// ----------------------------------------------------------------------------
module bpbs_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpbs_pkg::cell_ctl_t       ctl,
	input  logic [bpbs_pkg::BYTE_W-1:0] shift_in,
	input  logic [bpbs_pkg::BYTE_W-1:0] pat_byte,
	input  logic                      active,
	output logic [bpbs_pkg::BYTE_W-1:0] byte_q,
	output logic                      eq_s1
);
	import bpbs_pkg::*;

	logic [BYTE_W-1:0] next_val;

	// window content after this transfer's shift, before any clear
	assign next_val = ctl.shift ? shift_in : byte_q;

	// window byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.accept) begin
			if (ctl.clear) begin
				byte_q <= '0;
			end else if (ctl.shift) begin
				byte_q <= shift_in;
			end
		end
	end

	// compare bit; cells past the pattern length always agree
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			eq_s1 <= !active || (next_val == pat_byte);
		end
	end

endmodule

FILE: src/bpbs_resolve.sv
// ----------------------------------------------------------------------------
// Match resolve stage
// Latches the earliest match of the current haystack and presents one
// result per haystack in an output register.
// ----------------------------------------------------------------------------
module bpbs_resolve (
	input  logic                clk,
	input  logic                arst_n,
	input  bpbs_pkg::s1_t       s1,
	output logic                stall,
	bpbs_out_if.source          result
);
	import bpbs_pkg::*;

	logic                found_q;
	logic [OFFSET_W-1:0] found_off_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic                adv;
	logic                load;
	logic                f_next;
	logic [OFFSET_W-1:0] off_next;

	// a finished haystack waits only for a full, untaken output register
	assign stall = s1.valid && s1.last && out_valid_q && !result.ready;
	assign adv   = !stall;
	assign load  = adv && s1.valid && s1.last;

	// first match wins; empty pattern matches at offset zero
	always_comb begin
		f_next   = found_q || s1.zero_len || (s1.cand && s1.wmatch);
		off_next = found_q ? found_off_q : (s1.zero_len ? '0 : s1.offset);
	end

	// per-haystack search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			found_off_q <= '0;
		end else if (adv && s1.valid) begin
			if (s1.last) begin
				found_q     <= 1'b0;
				found_off_q <= '0;
			end else begin
				found_q     <= f_next;
				found_off_q <= off_next;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_found_q <= f_next;
			out_off_q   <= f_next ? off_next : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.match_found  = out_found_q;
	assign result.match_offset = out_off_q;

endmodule

FILE: src/bounded_pattern_byte_search_unit.sv
// ----------------------------------------------------------------------------
// Bounded pattern byte search unit
// Finds the first occurrence of a configured pattern of up to 32 bytes in a
// stream of haystack bytes and reports found flag and start offset per
// haystack.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  haystack   in   valid/ready    haystack_byte[7:0], last_byte
//  result     out  valid/ready    match_found, match_offset[31:0]
//  cfg        in   cfg_we         cfg_index[2:0], cfg_data[63:0]
//
// One byte per cycle while input ready is high. A byte's compare is registered
// in the cell row (stage 1); the resolve stage then latches the match from
// stage 1 and, for the last byte, loads the result into the output register.
// Reset empties window, position counter and pattern registers at once.
// Input ready drops only while a finished haystack waits on a full output
// register that the sink does not take.
// ----------------------------------------------------------------------------
module bounded_pattern_byte_search_unit #(
	parameter int MAX_PATTERN_BYTES = 32,
	parameter int POSITION_BITS     = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpbs_pkg::CFG_DATA_W-1:0] cfg_data,
	bpbs_in_if.sink                        haystack,
	bpbs_out_if.source                     result
);
	import bpbs_pkg::*;

	`include "assert_macros.svh"

	logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]  pat_word_q;
	logic [PAT_BYTES-1:0][BYTE_W-1:0]      pat_arr;
	logic [LEN_W-1:0]                      pat_len_q;
	logic [POSITION_BITS-1:0]              pos_q;
	logic [POSITION_BITS-1:0]              pos_new;
	logic                                  sat;
	logic                                  stall;
	logic                                  adv;
	logic                                  accept;
	cell_ctl_t                             ctl;
	logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] win;
	logic [MAX_PATTERN_BYTES-1:0]          eq_s1;
	logic                                  valid_s1;
	logic                                  last_s1;
	logic                                  zero_len_s1;
	logic                                  cand_s1;
	logic [OFFSET_W-1:0]                   offset_s1;
	s1_t                                   s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_word_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAT_0_7:   pat_word_q[0] <= cfg_data;
				REG_PAT_8_15:  pat_word_q[1] <= cfg_data;
				REG_PAT_16_23: pat_word_q[2] <= cfg_data;
				REG_PAT_24_31: pat_word_q[3] <= cfg_data;
				REG_PAT_LEN:   pat_len_q     <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_arr = pat_word_q;

	// handshake and pipeline advance
	assign adv            = !stall;
	assign haystack.ready = adv;
	assign accept         = haystack.valid && adv;

	// position counter saturates at all ones
	assign sat     = &pos_q;
	assign pos_new = sat ? pos_q : pos_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= haystack.last_byte ? '0 : pos_new;
		end
	end

	assign ctl.accept = accept;
	assign ctl.shift  = !sat;
	assign ctl.clear  = haystack.last_byte;
	assign ctl.load   = adv;

	// cell row: cell j holds the byte received j transfers ago
	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
		logic [LEN_W-1:0]  sel_diff;
		logic              active;
		logic [BYTE_W-1:0] shift_in;

		// pattern byte len-1-j lines up with this cell
		assign sel_diff = pat_len_q - LEN_W'(j + 1);
		assign active   = LEN_W'(j) < pat_len_q;

		if (j == 0) begin : g_head
			assign shift_in = haystack.haystack_byte;
		end else begin : g_body
			assign shift_in = win[j-1];
		end

		bpbs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.shift_in (shift_in),
			.pat_byte (pat_arr[sel_diff[PAT_IDX_W-1:0]]),
			.active   (active),
			.byte_q   (win[j]),
			.eq_s1    (eq_s1[j])
		);
	end

	// stage 1 control and offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1     <= haystack.last_byte;
			zero_len_s1 <= pat_len_q == '0;
			cand_s1     <= (pat_len_q != '0)
				&& (pat_len_q <= LEN_W'(MAX_PATTERN_BYTES))
				&& (pos_new >= POSITION_BITS'(pat_len_q));
			offset_s1   <= OFFSET_W'(pos_new - POSITION_BITS'(pat_len_q));
		end
	end

	assign s1.valid    = valid_s1;
	assign s1.last     = last_s1;
	assign s1.zero_len = zero_len_s1;
	assign s1.cand     = cand_s1;
	assign s1.wmatch   = &eq_s1;
	assign s1.offset   = offset_s1;

	bpbs_resolve u_resolve (
		.clk    (clk),
		.arst_n (arst_n),
		.s1     (s1),
		.stall  (stall),
		.result (result)
	);

	// checks
	`ASSERT_NEXT(a_accept_to_s1, accept, valid_s1, "accepted byte did not reach stage 1")
	`ASSERT_NEXT(a_last_clears_pos, accept && haystack.last_byte, pos_q == '0,
		"position not cleared after last byte")
	`ASSERT_IMPL(a_stall_cause, !haystack.ready, result.valid && !result.ready,
		"input stalled without a blocked result")
	`ASSERT_NEXT(a_empty_found, valid_s1 && last_s1 && zero_len_s1 && adv,
		result.valid && result.match_found && result.match_offset == '0,
		"empty pattern did not report a match at offset zero")

endmodule
